@@ rtl/lbph_pkg.sv @@
// Shared types, constants and the pattern-code function for the LBP histogram.
// No dependencies.
package lbph_pkg;

	localparam int MAX_WIDTH_DEF  = 1280;
	localparam int BIN_COUNT_DEF  = 256;
	localparam int COUNT_BITS_DEF = 21;
	localparam int BIN_BITS       = 8;
	localparam int PIX_BITS       = 8;
	localparam int DIM_BITS       = 11;

	localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 11'd480;

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		HK_INC   = 2'd0,
		HK_READ  = 2'd1,
		HK_CLEAR = 2'd2
	} hist_kind_t;

	typedef enum logic [2:0] {
		IT_STORE = 3'd0,
		IT_PIXEL = 3'd1,
		IT_READ  = 3'd2,
		IT_CLEAR = 3'd3
	} item_t;

	typedef struct packed {
		hist_kind_t          kind;
		logic [BIN_BITS-1:0] addr;
		logic                done;
	} hist_req_t;

	function automatic logic [7:0] lbp_code(
		input logic [PIX_BITS-1:0] tl, input logic [PIX_BITS-1:0] tp,
		input logic [PIX_BITS-1:0] tr, input logic [PIX_BITS-1:0] rt,
		input logic [PIX_BITS-1:0] br, input logic [PIX_BITS-1:0] bt,
		input logic [PIX_BITS-1:0] bl, input logic [PIX_BITS-1:0] lf,
		input logic [PIX_BITS-1:0] k);
		return {lf >= k, bl >= k, bt >= k, br >= k, rt >= k, tr >= k, tp >= k, tl >= k};
	endfunction

endpackage

@@ rtl/lbph_hist.sv @@
// Histogram RAM with read-modify-write, per-bin valid bits and result register.
// Depends on lbph_pkg.
module lbph_hist #(
	parameter int BIN_COUNT  = lbph_pkg::BIN_COUNT_DEF,
	parameter int COUNT_BITS = lbph_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  lbph_pkg::hist_req_t           req,
	output logic                          adv,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [COUNT_BITS-1:0]         bin_count,
	output logic [lbph_pkg::BIN_BITS-1:0] bin_number,
	output logic                          frame_complete
);
	import lbph_pkg::*;

	logic [COUNT_BITS-1:0] mem [BIN_COUNT];
	logic [COUNT_BITS-1:0] rd_q;
	logic [BIN_COUNT-1:0]  bin_valid_q;
	logic                  h2_valid_s2;
	hist_req_t             h2_s2;
	logic                  wr_en_q;
	logic [BIN_BITS-1:0]   wr_addr_q;
	logic [COUNT_BITS-1:0] wr_data_q;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] nxt;
	logic                  we;

	assign adv = !(h2_valid_s2 && h2_s2.kind == HK_READ && out_valid && !out_ready);
	assign we  = adv && h2_valid_s2 && h2_s2.kind == HK_INC;

	always_comb begin
		if (wr_en_q && wr_addr_q == h2_s2.addr) begin
			cur = wr_data_q;
		end else if (bin_valid_q[h2_s2.addr]) begin
			cur = rd_q;
		end else begin
			cur = '0;
		end
		nxt = (&cur) ? cur : cur + COUNT_BITS'(1);
	end

	always_ff @(posedge clk) begin
		if (adv && req_valid) begin
			rd_q <= mem[req.addr];
		end
		if (we) begin
			mem[h2_s2.addr] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h2_valid_s2 <= 1'b0;
			bin_valid_q <= '0;
			wr_en_q     <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (adv) begin
				h2_valid_s2 <= req_valid;
				wr_en_q     <= we;
			end
			if (we) begin
				bin_valid_q[h2_s2.addr] <= 1'b1;
			end
			if (adv && h2_valid_s2 && h2_s2.kind == HK_CLEAR) begin
				bin_valid_q <= '0;
			end
			if (adv && h2_valid_s2 && h2_s2.kind == HK_READ) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h2_s2     <= req;
			wr_addr_q <= h2_s2.addr;
			wr_data_q <= nxt;
		end
		if (adv && h2_valid_s2 && h2_s2.kind == HK_READ) begin
			bin_count      <= cur;
			bin_number     <= h2_s2.addr;
			frame_complete <= h2_s2.done;
		end
	end

endmodule

@@ rtl/lbp_histogram_top.sv @@
// Top level of the LBP histogram: counters, line RAM, 3x3 window and code issue.
// Depends on lbph_pkg and lbph_hist.
//
// Takes one transfer per clock. A pixel on the last column yields two pattern
// codes and one on the last row up to four; each code needs one slot of the
// single histogram read-modify-write port, so such pixels hold the input until
// their codes are issued. A read passes the s1 and s2 registers and the
// histogram stage to an output register, later behind queued codes; a read
// stalls the pipeline only while that register still holds an untaken result.
// Clear takes effect in order. One line RAM of MAX_WIDTH words keeps two rows.
module lbp_histogram_top #(
	parameter int MAX_WIDTH  = lbph_pkg::MAX_WIDTH_DEF,
	parameter int BIN_COUNT  = lbph_pkg::BIN_COUNT_DEF,
	parameter int COUNT_BITS = lbph_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [lbph_pkg::DIM_BITS-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic [lbph_pkg::PIX_BITS-1:0] pixel,
	input  logic [lbph_pkg::BIN_BITS-1:0] bin_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [COUNT_BITS-1:0]         bin_count,
	output logic [lbph_pkg::BIN_BITS-1:0] bin_number,
	output logic                          frame_complete
);
	import lbph_pkg::*;

	localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMPW = ((AW > DIM_BITS) ? AW : DIM_BITS) + 1;

	logic [DIM_BITS-1:0] width_q, height_q;
	logic [AW-1:0]       col_q;
	logic [DIM_BITS-1:0] row_q;
	logic                done_q;

	logic [CMPW-1:0]     w_eff;
	logic [DIM_BITS:0]   h_eff;
	logic                last_col, last_row, accept;

	logic [2*PIX_BITS-1:0] lm [MAX_WIDTH];
	logic [2*PIX_BITS-1:0] lm_rd_q;
	logic                  lm_re, lm_we;
	logic [2*PIX_BITS-1:0] lm_wdata;

	logic                s1_valid_q;
	item_t               s1_item_q;
	logic [AW-1:0]       s1_col_q;
	logic                s1_bank_q, s1_row1_q, s1_lc_q, s1_lr_q, s1_c1_q, s1_cone_q;
	logic [PIX_BITS-1:0] s1_px_q;
	logic [BIN_BITS-1:0] s1_bin_q;
	logic                s1_done_q;
	logic                s1_adv;

	logic [PIX_BITS-1:0] win_q [3][3];
	logic [PIX_BITS-1:0] nw [3][3];
	logic [PIX_BITS-1:0] above, mid;
	logic [1:0]          lc;
	logic [7:0]          code_a, code_b, code_c, code_d;
	logic [3:0]          new_mask;

	logic                s2_valid_q;
	hist_kind_t          s2_kind_q;
	logic [3:0]          s2_mask_q;
	logic [7:0]          s2_code_q [4];
	logic [BIN_BITS-1:0] s2_bin_q;
	logic                s2_done_q;
	logic                s2_last, s2_take;
	logic [BIN_BITS-1:0] issue_code;
	hist_req_t           req;
	logic                h_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_comb begin
		if (width_q < DIM_BITS'(2)) begin
			w_eff = CMPW'(2);
		end else if (CMPW'(width_q) > CMPW'(MAX_WIDTH)) begin
			w_eff = CMPW'(MAX_WIDTH);
		end else begin
			w_eff = CMPW'(width_q);
		end
		h_eff    = (height_q < DIM_BITS'(2)) ? (DIM_BITS+1)'(2) : {1'b0, height_q};
		last_col = (CMPW'(col_q) + CMPW'(1)) >= w_eff;
		last_row = ({1'b0, row_q} + (DIM_BITS+1)'(1)) >= h_eff;
	end

	assign accept = in_valid && in_ready;
	assign lm_re  = accept && op_t'(op) == OP_PIXEL && !done_q;

	// Frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			if (op_t'(op) == OP_CLEAR) begin
				col_q  <= '0;
				row_q  <= '0;
				done_q <= 1'b0;
			end else if (lm_re) begin
				if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						done_q <= 1'b1;
					end else begin
						row_q <= row_q + DIM_BITS'(1);
					end
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	// Line RAM: low half holds even rows, high half odd rows
	assign lm_we    = s1_adv && s1_valid_q && (s1_item_q == IT_STORE || s1_item_q == IT_PIXEL);
	assign lm_wdata = s1_bank_q ? {s1_px_q, lm_rd_q[PIX_BITS-1:0]}
	                            : {lm_rd_q[2*PIX_BITS-1:PIX_BITS], s1_px_q};

	always_ff @(posedge clk) begin
		if (lm_re) begin
			lm_rd_q <= lm[col_q];
		end
		if (lm_we) begin
			lm[s1_col_q] <= lm_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= accept && (lm_re || op_t'(op) == OP_READ || op_t'(op) == OP_CLEAR);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (op_t'(op))
				OP_READ:  s1_item_q <= IT_READ;
				OP_CLEAR: s1_item_q <= IT_CLEAR;
				default:  s1_item_q <= (row_q == '0) ? IT_STORE : IT_PIXEL;
			endcase
			s1_col_q  <= col_q;
			s1_bank_q <= row_q[0];
			s1_row1_q <= row_q == DIM_BITS'(1);
			s1_lc_q   <= last_col;
			s1_lr_q   <= last_row;
			s1_c1_q   <= col_q != '0;
			s1_cone_q <= col_q == AW'(1);
			s1_px_q   <= pixel;
			s1_bin_q  <= bin_index;
			s1_done_q <= done_q;
		end
	end

	// Window shift and pattern codes
	always_comb begin
		above = s1_row1_q ? s1_px_q
		      : (s1_bank_q ? lm_rd_q[2*PIX_BITS-1:PIX_BITS] : lm_rd_q[PIX_BITS-1:0]);
		mid   = s1_bank_q ? lm_rd_q[PIX_BITS-1:0] : lm_rd_q[2*PIX_BITS-1:PIX_BITS];
		for (int i = 0; i < 3; i++) begin
			nw[i][0] = win_q[i][1];
			nw[i][1] = win_q[i][2];
		end
		nw[0][2] = above;
		nw[1][2] = mid;
		nw[2][2] = s1_px_q;
		lc = s1_cone_q ? 2'd2 : 2'd0;
		code_a = lbp_code(nw[0][lc], nw[0][1], nw[0][2], nw[1][2], nw[2][2], nw[2][1],
			nw[2][lc], nw[1][lc], nw[1][1]);
		code_b = lbp_code(nw[1][lc], nw[1][1], nw[1][2], nw[2][2], nw[1][2], nw[1][1],
			nw[1][lc], nw[2][lc], nw[2][1]);
		code_c = lbp_code(nw[0][1], nw[0][2], nw[0][1], nw[1][1], nw[2][1], nw[2][2],
			nw[2][1], nw[1][1], nw[1][2]);
		code_d = lbp_code(nw[1][1], nw[1][2], nw[1][1], nw[2][1], nw[1][1], nw[1][2],
			nw[1][1], nw[2][1], nw[2][2]);
		new_mask = {s1_lc_q && s1_lr_q, s1_lc_q, s1_c1_q && s1_lr_q, s1_c1_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (s1_adv && s1_valid_q) begin
			if (s1_item_q == IT_PIXEL) begin
				win_q <= nw;
			end else if (s1_item_q == IT_CLEAR) begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						win_q[i][j] <= '0;
					end
				end
			end
		end
	end

	// Code issue: one histogram access per cycle while the histogram advances
	assign s2_last  = !s2_valid_q || s2_kind_q != HK_INC || (s2_mask_q & (s2_mask_q - 4'd1)) == '0;
	assign s2_take  = h_adv && s2_last;
	assign s1_adv   = s2_take;
	assign in_ready = !s1_valid_q || s2_take;

	always_comb begin
		if (s2_kind_q != HK_INC) begin
			issue_code = s2_bin_q;
		end else if (s2_mask_q[0]) begin
			issue_code = s2_code_q[0];
		end else if (s2_mask_q[1]) begin
			issue_code = s2_code_q[1];
		end else if (s2_mask_q[2]) begin
			issue_code = s2_code_q[2];
		end else begin
			issue_code = s2_code_q[3];
		end
		req.kind = s2_kind_q;
		req.addr = issue_code;
		req.done = s2_done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			s2_kind_q  <= HK_INC;
			s2_mask_q  <= '0;
		end else if (s2_take) begin
			s2_mask_q <= new_mask;
			if (!s1_valid_q) begin
				s2_valid_q <= 1'b0;
			end else begin
				case (s1_item_q)
					IT_PIXEL: begin
						s2_valid_q <= new_mask != '0;
						s2_kind_q  <= HK_INC;
					end
					IT_READ: begin
						s2_valid_q <= 1'b1;
						s2_kind_q  <= HK_READ;
					end
					IT_CLEAR: begin
						s2_valid_q <= 1'b1;
						s2_kind_q  <= HK_CLEAR;
					end
					default: s2_valid_q <= 1'b0;
				endcase
			end
		end else if (h_adv && s2_valid_q) begin
			s2_mask_q <= s2_mask_q & (s2_mask_q - 4'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take) begin
			s2_code_q[0] <= code_a;
			s2_code_q[1] <= code_b;
			s2_code_q[2] <= code_c;
			s2_code_q[3] <= code_d;
			s2_bin_q     <= s1_bin_q;
			s2_done_q    <= s1_done_q;
		end
	end

	lbph_hist #(
		.BIN_COUNT (BIN_COUNT),
		.COUNT_BITS(COUNT_BITS)
	) u_hist (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (s2_valid_q),
		.req           (req),
		.adv           (h_adv),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.bin_count     (bin_count),
		.bin_number    (bin_number),
		.frame_complete(frame_complete)
	);

	a_lm_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		lm_re && lm_we |-> col_q != s1_col_q)
		else $error("line RAM read and write hit the same column");

	a_pixel_enters: assert property (@(posedge clk) disable iff (!arst_n)
		lm_re |=> s1_valid_q)
		else $error("accepted pixel lost before window stage");

	a_inc_has_codes: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && s2_kind_q == HK_INC |-> s2_mask_q != '0)
		else $error("increment slot holds no codes");

endmodule

@@ verif/lbp_histogram_top_tb.sv @@
// Self-checking testbench for lbp_histogram_top: a pixel/read/clear stream with
// a built-in LBP histogram predictor, random idling on both sides.
// Depends on lbph_pkg and the RTL of lbp_histogram_top.
module lbp_histogram_top_tb;
	import lbph_pkg::*;

	localparam int MAXW  = MAX_WIDTH_DEF;
	localparam int CBITS = COUNT_BITS_DEF;

	typedef struct packed {
		op_t                 op;
		logic [PIX_BITS-1:0] pixel;
		logic [BIN_BITS-1:0] bin;
	} txn_t;

	typedef struct packed {
		logic [CBITS-1:0]    count;
		logic [BIN_BITS-1:0] bin;
		logic                done;
	} bin_rd_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [DIM_BITS-1:0] cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          op;
	logic [PIX_BITS-1:0] pixel;
	logic [BIN_BITS-1:0] bin_index;
	logic                out_valid;
	logic                out_ready;
	logic [CBITS-1:0]    bin_count;
	logic [BIN_BITS-1:0] bin_number;
	logic                frame_complete;

	lbp_histogram_top u_dut (.*);

	// predictor state
	logic [DIM_BITS-1:0] p_width, p_height;
	logic [7:0]          p_lines [2*MAXW];
	logic [7:0]          p_win [3][3];
	logic [CBITS-1:0]    p_hist [256];
	int unsigned         p_col, p_row;
	bit                  p_done;

	txn_t    pending_q [$];
	bin_rd_t bin_rd_q [$];
	int      errors, reads_seen, cycles, hold_off, in_gap;
	bit      hold_req, hold_used, in_acc_q;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			cycles <= 0;
		end else begin
			cycles <= cycles + 1;
		end
		if (cycles > 3000000) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void pred_clear();
		foreach (p_win[i, j]) p_win[i][j] = '0;
		foreach (p_hist[i]) p_hist[i] = '0;
		p_col = 0;
		p_row = 0;
		p_done = 1'b0;
	endfunction

	function automatic void pred_code(int t, int c, int b, int l, int m, int r);
		logic [7:0] k, code;
		k = p_win[c][m];
		code = {p_win[c][l] >= k, p_win[b][l] >= k, p_win[b][m] >= k, p_win[b][r] >= k,
			p_win[c][r] >= k, p_win[t][r] >= k, p_win[t][m] >= k, p_win[t][l] >= k};
		if (p_hist[code] != '1)
			p_hist[code] = p_hist[code] + 1'b1;
	endfunction

	function automatic void pred_pixel(logic [7:0] px);
		int unsigned w, h, c, here, prev;
		bit lc, lr;
		int l;
		logic [7:0] above, mid;
		w = (p_width < 2) ? 2 : (p_width > MAXW) ? MAXW : p_width;
		h = (p_height < 2) ? 2 : p_height;
		c = (p_col >= MAXW) ? MAXW - 1 : p_col;
		lc = (c + 1 >= w);
		lr = (p_row + 1 >= h);
		if (p_row == 0) begin
			p_lines[c] = px;
		end else begin
			here = (p_row % 2) * MAXW + c;
			prev = ((p_row - 1) % 2) * MAXW + c;
			above = (p_row == 1) ? px : p_lines[here];
			mid = p_lines[prev];
			p_lines[here] = px;
			for (int i = 0; i < 3; i++) begin
				p_win[i][0] = p_win[i][1];
				p_win[i][1] = p_win[i][2];
			end
			p_win[0][2] = above;
			p_win[1][2] = mid;
			p_win[2][2] = px;
			if (c >= 1) begin
				l = (c == 1) ? 2 : 0;
				pred_code(0, 1, 2, l, 1, 2);
				if (lr) pred_code(1, 2, 1, l, 1, 2);
			end
			if (lc) begin
				pred_code(0, 1, 2, 1, 2, 1);
				if (lr) pred_code(1, 2, 1, 1, 2, 1);
			end
		end
		if (lc) begin
			p_col = 0;
			if (lr) p_done = 1'b1;
			else p_row = (p_row + 1) & 11'h7FF;
		end else begin
			p_col = c + 1;
		end
	endfunction

	// driver: a new item only once the previous one has been transferred
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			op        <= '0;
			pixel     <= '0;
			bin_index <= '0;
			in_gap    <= 0;
		end else if (!in_valid || in_acc_q) begin
			if (in_gap > 0) begin
				in_gap   <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_q.size() > 0 && ($urandom_range(9) < 7 || hold_req)) begin
				in_valid  <= 1'b1;
				op        <= pending_q[0].op;
				pixel     <= pending_q[0].pixel;
				bin_index <= pending_q[0].bin;
				pending_q.pop_front();
				if (!hold_req && $urandom_range(99) == 0) in_gap <= $urandom_range(40, 10);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// accepted transfers feed the predictor
	always @(posedge clk) begin
		if (!arst_n) begin
			in_acc_q <= 1'b0;
			foreach (p_lines[i]) p_lines[i] = '0;
			pred_clear();
		end else begin
			in_acc_q <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				case (op_t'(op))
					OP_PIXEL: if (!p_done) pred_pixel(pixel);
					OP_READ:  bin_rd_q.insert(bin_rd_q.size(),
						bin_rd_t'{p_hist[bin_index], bin_index, p_done});
					OP_CLEAR: pred_clear();
					default: ;
				endcase
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_off  <= 0;
			hold_used <= 1'b0;
		end else if (hold_req && !hold_used) begin
			hold_used <= 1'b1;
			hold_off  <= 150;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(15) == 0) ? 1'b0 : ($urandom_range(3) != 0);
			if ($urandom_range(199) == 0) hold_off <= $urandom_range(60, 20);
		end
	end

	// monitor
	always @(posedge clk) begin
		bin_rd_t e;
		int      n;
		n = 0;
		if (!arst_n) begin
			errors     <= 0;
			reads_seen <= 0;
		end else if (out_valid && out_ready) begin
			reads_seen <= reads_seen + 1;
			if (bin_rd_q.size() == 0) begin
				$error("result with no expectation: bin_number %0d", bin_number);
				n = 1;
			end else begin
				e = bin_rd_q.pop_front();
				if (bin_count !== e.count) begin
					$error("bin_count exp %0d got %0d", e.count, bin_count);
					n = n + 1;
				end
				if (bin_number !== e.bin) begin
					$error("bin_number exp %0d got %0d", e.bin, bin_number);
					n = n + 1;
				end
				if (frame_complete !== e.done) begin
					$error("frame_complete exp %0d got %0d", e.done, frame_complete);
					n = n + 1;
				end
			end
			errors <= errors + n;
		end
	end

	task automatic push(op_t o, int px, int b);
		pending_q.insert(pending_q.size(), txn_t'{o, px[7:0], b[7:0]});
	endtask

	task automatic drain();
		wait (pending_q.size() == 0);
		@(negedge clk);
		while (in_valid) @(negedge clk);
		while (bin_rd_q.size() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[DIM_BITS-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH) p_width = val[DIM_BITS-1:0];
		else p_height = val[DIM_BITS-1:0];
	endtask

	// one frame of pixels; pixel style picks flat, extreme or random data
	task automatic push_frame(int w, int h, int style);
		int v;
		push(OP_CLEAR, 0, 0);
		for (int i = 0; i < w * h; i++) begin
			case (style)
				0: v = 128;
				1: v = $urandom_range(1) ? 255 : 0;
				default: v = $urandom_range(255);
			endcase
			push(OP_PIXEL, v, 0);
			if ($urandom_range(19) == 0) push(OP_READ, 0, $urandom_range(255));
			if ($urandom_range(49) == 0) push(OP_NONE, $urandom_range(255), $urandom_range(255));
		end
		for (int i = 0; i < 4; i++) push(OP_READ, 0, $urandom_range(255));
		push(OP_PIXEL, $urandom_range(255), 0);
		push(OP_READ, 0, 255);
		push(OP_READ, 0, 0);
	endtask

	initial begin
		int w, h;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		hold_req = 0;
		p_width = WIDTH_RESET;
		p_height = HEIGHT_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reads of an empty histogram, idle op, smallest image
		push(OP_READ, 0, 0);
		push(OP_READ, 0, 255);
		push(OP_NONE, 255, 170);
		drain();
		write_reg(REG_WIDTH, 0);
		write_reg(REG_HEIGHT, 1);
		push(OP_CLEAR, 0, 0);
		push(OP_PIXEL, 0, 0);
		push(OP_PIXEL, 255, 0);
		push(OP_PIXEL, 255, 0);
		push(OP_PIXEL, 0, 0);
		push(OP_PIXEL, 77, 0);
		for (int b = 0; b < 8; b++) push(OP_READ, 0, 1 << b);
		push(OP_READ, 0, 85);
		drain();

		// widest row: a width above the line RAM size is clamped to MAX_WIDTH
		write_reg(REG_WIDTH, 2047);
		write_reg(REG_HEIGHT, 2);
		push(OP_CLEAR, 0, 0);
		for (int i = 0; i < MAXW + 6; i++) push(OP_PIXEL, 128, 0);
		push(OP_READ, 0, 255);
		push(OP_READ, 0, 0);
		push(OP_READ, 0, 127);
		drain();

		// long receiver stall while the sender keeps going
		hold_req = 1;
		write_reg(REG_WIDTH, 3);
		write_reg(REG_HEIGHT, 3);
		push_frame(3, 3, 2);
		for (int i = 0; i < 10; i++) push(OP_READ, 0, i);
		drain();
		hold_req = 0;

		// random small frames
		for (int f = 0; f < 3; f++) begin
			w = $urandom_range(10, 2);
			h = $urandom_range(6, 2);
			write_reg(REG_WIDTH, w);
			write_reg(REG_HEIGHT, h);
			push_frame(w, h, $urandom_range(2));
			drain();
		end
		write_reg(REG_WIDTH, 640);
		write_reg(REG_HEIGHT, 1024);
		push_frame(2, 1, 2);
		drain();
		$display("Checked %0d bin reads over small frames and a full-width row, with stalls.",
			reads_seen);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
